// File: design/art_pkg.sv
// shared types and constants for the transactional-region time accounting block
package art_pkg;

	localparam int unsigned DEF_TIME_BITS = 48;
	localparam int unsigned OP_W          = 4;
	localparam int unsigned STATUS_W      = 3;
	localparam int unsigned TOTAL_W       = 64;
	localparam int unsigned NUM_CAT       = 7;

	// category slots in the totals vector
	localparam int unsigned CAT_DUR     = 0;
	localparam int unsigned CAT_MUTEX   = 1;
	localparam int unsigned CAT_QUEUE   = 2;
	localparam int unsigned CAT_COMMIT  = 3;
	localparam int unsigned CAT_ABORT   = 4;
	localparam int unsigned CAT_ACTIVE  = 5;
	localparam int unsigned CAT_BACKOFF = 6;

	typedef enum logic [OP_W-1:0] {
		OP_REGION_BEGIN = 4'd0,
		OP_REGION_END   = 4'd1,
		OP_HTM_BEGIN    = 4'd2,
		OP_ABORT        = 4'd3,
		OP_COMMIT       = 4'd4,
		OP_LOCK_REQ     = 4'd5,
		OP_LOCK_ACQ     = 4'd6,
		OP_LOCK_REL     = 4'd7,
		OP_FB_WAIT      = 4'd8,
		OP_BACKOFF      = 4'd9,
		OP_WAIT_END     = 4'd10
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_NO_BEGIN    = 3'd1,
		ST_BAD_LOCK    = 3'd2,
		ST_BAD_WAIT    = 3'd3,
		ST_UNEXPECTED  = 3'd4,
		ST_NOT_OPEN    = 3'd5,
		ST_OVER_ACCNT  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		PH_NONE      = 3'd0,
		PH_LOCK_REQ  = 3'd1,
		PH_LOCK_HELD = 3'd2,
		PH_ACTIVE    = 3'd3,
		PH_BACKOFF   = 3'd4
	} phase_t;

	// control flags of the region tracker
	typedef struct packed {
		logic   region_open;
		logic   attempt_pending;
		phase_t phase;
	} ctl_t;

	typedef logic [NUM_CAT-1:0][TOTAL_W-1:0] totals_t;

endpackage

// File: design/art_if.sv
// event and result channel interfaces
interface art_evt_if #(parameter int unsigned TIME_BITS = art_pkg::DEF_TIME_BITS) ();
	import art_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      operation;
	logic [TIME_BITS-1:0] timestamp;

	modport source (output valid, output operation, output timestamp, input ready);
	modport sink (input valid, input operation, input timestamp, output ready);
endinterface

interface art_res_if ();
	import art_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic [TOTAL_W-1:0] duration_total;
	logic [TOTAL_W-1:0] in_mutex_total;
	logic [TOTAL_W-1:0] mutex_queue_total;
	logic [TOTAL_W-1:0] committed_total;
	logic [TOTAL_W-1:0] aborted_total;
	logic [TOTAL_W-1:0] active_wait_total;
	logic [TOTAL_W-1:0] backoff_total;

	modport source (output valid, output status, output duration_total,
		output in_mutex_total, output mutex_queue_total, output committed_total,
		output aborted_total, output active_wait_total, output backoff_total,
		input ready);
	modport sink (input valid, input status, input duration_total,
		input in_mutex_total, input mutex_queue_total, input committed_total,
		input aborted_total, input active_wait_total, input backoff_total,
		output ready);
endinterface

// File: design/art_core.sv
// next-state and status evaluation for one region event
module art_core #(
	parameter int unsigned TIME_BITS = art_pkg::DEF_TIME_BITS
) (
	input  logic [art_pkg::OP_W-1:0]    operation,
	input  logic [TIME_BITS-1:0]        timestamp,
	input  art_pkg::ctl_t               ctl,
	input  logic [TIME_BITS-1:0]        region_start,
	input  logic [TIME_BITS-1:0]        attempt_start,
	input  logic [TIME_BITS-1:0]        phase_first,
	input  logic [TIME_BITS-1:0]        phase_second,
	input  logic [art_pkg::TOTAL_W-1:0] accounted,
	input  art_pkg::totals_t            totals,
	output art_pkg::status_t            status,
	output art_pkg::ctl_t               ctl_nxt,
	output logic [TIME_BITS-1:0]        region_start_nxt,
	output logic [TIME_BITS-1:0]        attempt_start_nxt,
	output logic [TIME_BITS-1:0]        phase_first_nxt,
	output logic [TIME_BITS-1:0]        phase_second_nxt,
	output logic [art_pkg::TOTAL_W-1:0] accounted_nxt,
	output art_pkg::totals_t            totals_nxt
);
	import art_pkg::*;

	logic [TIME_BITS-1:0] dur_span;
	logic [TIME_BITS-1:0] att_span;
	logic [TIME_BITS-1:0] first_span;
	logic [TIME_BITS-1:0] queue_span;
	logic [TIME_BITS-1:0] mutex_span;
	status_t              pend_err;
	logic                 acc_en;
	logic [TOTAL_W:0]     acc_add;
	logic [TOTAL_W+1:0]   acc_sum;
	logic [TOTAL_W-1:0]   acc_sat;
	logic [TOTAL_W-1:0]   accounted_base;
	totals_t              cat_add;
	op_t                  op_e;

	// spans wrap at the timestamp width
	assign dur_span   = timestamp - region_start;
	assign att_span   = timestamp - attempt_start;
	assign first_span = timestamp - phase_first;
	assign queue_span = phase_second - phase_first;
	assign mutex_span = timestamp - phase_second;
	assign op_e       = op_t'(operation);

	// error owed to an open lock or wait sequence
	always_comb begin
		case (ctl.phase)
			PH_LOCK_REQ, PH_LOCK_HELD: pend_err = ST_BAD_LOCK;
			PH_ACTIVE, PH_BACKOFF:     pend_err = ST_BAD_WAIT;
			default:                   pend_err = ST_OK;
		endcase
	end

	// event decode
	always_comb begin
		status            = ST_OK;
		ctl_nxt           = ctl;
		region_start_nxt  = region_start;
		attempt_start_nxt = attempt_start;
		phase_first_nxt   = phase_first;
		phase_second_nxt  = phase_second;
		accounted_base    = accounted;
		acc_en            = 1'b0;
		acc_add           = '0;
		cat_add           = '0;

		if (operation > OP_WAIT_END) begin
			status = ST_UNEXPECTED;
		end else if (op_e == OP_REGION_BEGIN) begin
			ctl_nxt.region_open     = 1'b1;
			ctl_nxt.attempt_pending = 1'b0;
			ctl_nxt.phase           = PH_NONE;
			region_start_nxt        = timestamp;
			attempt_start_nxt       = '0;
			phase_first_nxt         = '0;
			phase_second_nxt        = '0;
			accounted_base          = '0;
		end else if (!ctl.region_open) begin
			status = ST_NOT_OPEN;
		end else begin
			case (op_e)
				OP_REGION_END: begin
					if (pend_err != ST_OK) begin
						status = pend_err;
					end else if (accounted > TOTAL_W'(dur_span)) begin
						status = ST_OVER_ACCNT;
					end else begin
						cat_add[CAT_DUR]        = TOTAL_W'(dur_span);
						ctl_nxt.region_open     = 1'b0;
						ctl_nxt.attempt_pending = 1'b0;
						accounted_base          = '0;
					end
				end
				OP_HTM_BEGIN: begin
					if (pend_err != ST_OK) begin
						status = pend_err;
					end else begin
						ctl_nxt.attempt_pending = 1'b1;
						attempt_start_nxt       = timestamp;
					end
				end
				OP_ABORT, OP_COMMIT: begin
					if (pend_err != ST_OK) begin
						status = pend_err;
					end else if (!ctl.attempt_pending) begin
						status = ST_NO_BEGIN;
					end else begin
						if (op_e == OP_ABORT) begin
							cat_add[CAT_ABORT] = TOTAL_W'(att_span);
						end else begin
							cat_add[CAT_COMMIT] = TOTAL_W'(att_span);
						end
						acc_en                  = 1'b1;
						acc_add                 = (TOTAL_W+1)'(att_span);
						ctl_nxt.attempt_pending = 1'b0;
					end
				end
				OP_LOCK_REQ, OP_FB_WAIT, OP_BACKOFF: begin
					if (pend_err != ST_OK) begin
						status = pend_err;
					end else begin
						case (op_e)
							OP_LOCK_REQ: ctl_nxt.phase = PH_LOCK_REQ;
							OP_FB_WAIT:  ctl_nxt.phase = PH_ACTIVE;
							default:     ctl_nxt.phase = PH_BACKOFF;
						endcase
						phase_first_nxt = timestamp;
					end
				end
				OP_LOCK_ACQ: begin
					if (ctl.phase == PH_LOCK_REQ) begin
						ctl_nxt.phase    = PH_LOCK_HELD;
						phase_second_nxt = timestamp;
					end else begin
						status = (pend_err != ST_OK) ? pend_err : ST_UNEXPECTED;
					end
				end
				OP_LOCK_REL: begin
					if (ctl.phase == PH_LOCK_HELD) begin
						cat_add[CAT_QUEUE] = TOTAL_W'(queue_span);
						cat_add[CAT_MUTEX] = TOTAL_W'(mutex_span);
						acc_en             = 1'b1;
						acc_add            = (TOTAL_W+1)'(queue_span)
							+ (TOTAL_W+1)'(mutex_span);
						ctl_nxt.phase      = PH_NONE;
					end else begin
						status = (pend_err != ST_OK) ? pend_err : ST_UNEXPECTED;
					end
				end
				OP_WAIT_END: begin
					if (ctl.phase == PH_ACTIVE || ctl.phase == PH_BACKOFF) begin
						if (ctl.phase == PH_ACTIVE) begin
							cat_add[CAT_ACTIVE] = TOTAL_W'(first_span);
						end else begin
							cat_add[CAT_BACKOFF] = TOTAL_W'(first_span);
						end
						acc_en        = 1'b1;
						acc_add       = (TOTAL_W+1)'(first_span);
						ctl_nxt.phase = PH_NONE;
					end else begin
						status = (pend_err != ST_OK) ? pend_err : ST_UNEXPECTED;
					end
				end
				default: begin
					status = ST_UNEXPECTED;
				end
			endcase
		end
	end

	// saturating region accounted count
	assign acc_sum       = {2'b00, accounted} + {1'b0, acc_add};
	assign acc_sat       = (acc_sum[TOTAL_W+1:TOTAL_W] != 2'b00) ? '1 : acc_sum[TOTAL_W-1:0];
	assign accounted_nxt = acc_en ? acc_sat : accounted_base;

	// per-category running totals
	always_comb begin
		for (int i = 0; i < NUM_CAT; i++) begin
			totals_nxt[i] = totals[i] + cat_add[i];
		end
	end

endmodule

// File: design/atomic_region_time_accounting_top.sv
// top level: event register, region tracker state and result word register
// an accepted event word passes through the event register and then the result word register
// throughput: one event word per cycle while the output is not stalled, set by the single evaluation stage
// a result word waiting on the output stalls the event channel once the event register is full
// reset: arst_n clears all region state and every running total to zero at once
// the result word totals are the tracker totals, loaded together with the status
module atomic_region_time_accounting_top #(
	parameter int unsigned TIME_BITS = art_pkg::DEF_TIME_BITS
) (
	input logic        clk,
	input logic        arst_n,
	art_evt_if.sink    evt,
	art_res_if.source  res
);
	import art_pkg::*;

	logic                 valid_s1;
	logic [OP_W-1:0]      op_s1;
	logic [TIME_BITS-1:0] ts_s1;
	logic                 res_valid_q;
	status_t              status_q;
	logic                 out_free;
	logic                 step;

	ctl_t                 ctl_q;
	logic [TIME_BITS-1:0] region_start_q;
	logic [TIME_BITS-1:0] attempt_start_q;
	logic [TIME_BITS-1:0] phase_first_q;
	logic [TIME_BITS-1:0] phase_second_q;
	logic [TOTAL_W-1:0]   accounted_q;
	totals_t              totals_q;

	status_t              status_c;
	ctl_t                 ctl_c;
	logic [TIME_BITS-1:0] region_start_c;
	logic [TIME_BITS-1:0] attempt_start_c;
	logic [TIME_BITS-1:0] phase_first_c;
	logic [TIME_BITS-1:0] phase_second_c;
	logic [TOTAL_W-1:0]   accounted_c;
	totals_t              totals_c;

	// handshake
	assign out_free  = !res_valid_q || res.ready;
	assign step      = valid_s1 && out_free;
	assign evt.ready = !valid_s1 || out_free;

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			op_s1 <= evt.operation;
			ts_s1 <= evt.timestamp;
		end
	end

	art_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.operation         (op_s1),
		.timestamp         (ts_s1),
		.ctl               (ctl_q),
		.region_start      (region_start_q),
		.attempt_start     (attempt_start_q),
		.phase_first       (phase_first_q),
		.phase_second      (phase_second_q),
		.accounted         (accounted_q),
		.totals            (totals_q),
		.status            (status_c),
		.ctl_nxt           (ctl_c),
		.region_start_nxt  (region_start_c),
		.attempt_start_nxt (attempt_start_c),
		.phase_first_nxt   (phase_first_c),
		.phase_second_nxt  (phase_second_c),
		.accounted_nxt     (accounted_c),
		.totals_nxt        (totals_c)
	);

	// tracker state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q     <= 1'b0;
			status_q        <= ST_OK;
			ctl_q           <= '{region_open: 1'b0, attempt_pending: 1'b0, phase: PH_NONE};
			region_start_q  <= '0;
			attempt_start_q <= '0;
			phase_first_q   <= '0;
			phase_second_q  <= '0;
			accounted_q     <= '0;
			totals_q        <= '0;
		end else begin
			if (out_free) begin
				res_valid_q <= valid_s1;
			end
			if (step) begin
				status_q        <= status_c;
				ctl_q           <= ctl_c;
				region_start_q  <= region_start_c;
				attempt_start_q <= attempt_start_c;
				phase_first_q   <= phase_first_c;
				phase_second_q  <= phase_second_c;
				accounted_q     <= accounted_c;
				totals_q        <= totals_c;
			end
		end
	end

	// result port
	assign res.valid             = res_valid_q;
	assign res.status            = status_q;
	assign res.duration_total    = totals_q[CAT_DUR];
	assign res.in_mutex_total    = totals_q[CAT_MUTEX];
	assign res.mutex_queue_total = totals_q[CAT_QUEUE];
	assign res.committed_total   = totals_q[CAT_COMMIT];
	assign res.aborted_total     = totals_q[CAT_ABORT];
	assign res.active_wait_total = totals_q[CAT_ACTIVE];
	assign res.backoff_total     = totals_q[CAT_BACKOFF];

endmodule

// File: design/art_checker.sv
// port-level checks for the region time accounting block, bound to the top level
module art_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        evt_valid,
	input logic                        evt_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [art_pkg::STATUS_W-1:0] status,
	input logic [art_pkg::TOTAL_W-1:0] duration_total,
	input logic [art_pkg::TOTAL_W-1:0] in_mutex_total,
	input logic [art_pkg::TOTAL_W-1:0] committed_total
);
	import art_pkg::*;

	// a result word is held until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status))
		else $error("result word dropped or changed while stalled");

	// an empty output side never blocks the event channel
	a_evt_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> evt_ready)
		else $error("event channel stalled with empty output");

	// totals move only together with a new result word
	a_totals_move: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable({duration_total, in_mutex_total, committed_total}) |-> res_valid)
		else $error("totals changed without a result word");

	// an accepted event with an idle output passes the event register and shows up as a result word if the output is ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && !res_valid ##1 res_ready |=> res_valid)
		else $error("result word missing after accepted event");

endmodule

bind atomic_region_time_accounting_top art_checker u_art_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.evt_valid       (evt.valid),
	.evt_ready       (evt.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.status          (res.status),
	.duration_total  (res.duration_total),
	.in_mutex_total  (res.in_mutex_total),
	.committed_total (res.committed_total)
);
